// ===== rtl/core/ssc_pkg.sv =====
// Package for the settable mm:ss timer with seven-segment outputs.
// Holds widths, reset values, register codes and the segment decoder.
// No dependencies.
package ssc_pkg;

    localparam int DIGITS    = 4;
    localparam int DIG_W     = 4;
    localparam int SEG_W     = 8;
    localparam int DB_W      = 4;
    localparam int TPS_W     = 7;
    localparam int SEL_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 7;

    typedef logic [DIG_W-1:0] digit_t;
    typedef logic [SEG_W-1:0] seg_t;
    typedef logic [DB_W-1:0]  db_count_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_TICKS   = 1'b0,
        REG_TICKS_PER_SECOND = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        db_count_t count;
        logic      press;
    } db_result_t;

    localparam db_count_t        DEBOUNCE_RESET  = 4'd10;
    localparam logic [TPS_W-1:0] TPS_RESET       = 7'd100;
    localparam seg_t             SEG_DASH        = 8'h40;
    localparam seg_t             SEG_BLANK       = 8'h00;
    localparam digit_t           DIGIT_MAX_TENS  = 4'd5;
    localparam digit_t           DIGIT_MAX_UNITS = 4'd9;

    function automatic seg_t seg_encode(digit_t d);
        seg_t s;
        unique case (d)
            4'h0:    s = 8'h3f;
            4'h1:    s = 8'h30;
            4'h2:    s = 8'h5b;
            4'h3:    s = 8'h4f;
            4'h4:    s = 8'h66;
            4'h5:    s = 8'h6d;
            4'h6:    s = 8'h7d;
            4'h7:    s = 8'h07;
            4'h8:    s = 8'h7f;
            4'h9:    s = 8'h6f;
            4'ha:    s = 8'h77;
            4'hb:    s = 8'h7f;
            4'hc:    s = 8'h39;
            4'hd:    s = 8'h3f;
            4'he:    s = 8'h79;
            default: s = 8'h71;
        endcase
        return s;
    endfunction

    // Counter starts on a low level; a press counts if still low on the match.
    function automatic db_result_t debounce(db_count_t count, db_count_t limit, logic level);
        db_result_t r;
        r.count = count;
        r.press = 1'b0;
        if (count == '0 && level) begin
            r.count = count;
        end
        else if (count == limit) begin
            r.count = '0;
            r.press = !level;
        end
        else begin
            r.count = count + db_count_t'(1);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/settable_seconds_counter_seven_segment.sv =====
// Top level of the settable mm:ss timer with four seven-segment patterns per tick.
// Depends on ssc_pkg (widths, register codes, segment decoder, debounce).
//
//  channel  | direction | fields                                  | handshake
//  ---------+-----------+-----------------------------------------+------------------
//  in       | in        | red_level, blue_level                   | in_valid/in_ready
//  out      | out       | digit0..3_segments, counting_flag,      | out_valid/out_ready
//           |           | set_mode_flag                           |
//  cfg      | in        | cfg_index, cfg_data                     | cfg_valid/cfg_ready
//
// One tick per cycle sustained while the output is not stalled; a result is presented after its transfer
// passes the input register, then one pass of state update into the result register.
// The elapsed time is kept as four BCD digits, so no division is needed.
// Reset loads the register defaults and shows dashes; cfg_ready is always high.
// A stalled output holds the result; one more tick waits in the input register.
module settable_seconds_counter_seven_segment (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          red_level,
    input  logic                          blue_level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ssc_pkg::seg_t                 digit0_segments,
    output ssc_pkg::seg_t                 digit1_segments,
    output ssc_pkg::seg_t                 digit2_segments,
    output ssc_pkg::seg_t                 digit3_segments,
    output logic                          counting_flag,
    output logic                          set_mode_flag,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ssc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ssc_pkg::CFG_W-1:0]     cfg_data
);
    import ssc_pkg::*;

    logic               in_valid_reg;
    logic               red_reg;
    logic               blue_reg;
    logic               out_valid_reg;
    seg_t               seg_reg [DIGITS];
    logic               counting_flag_reg;
    logic               set_mode_flag_reg;

    db_count_t          debounce_ticks_reg;
    logic [TPS_W-1:0]   tps_reg;
    db_count_t          red_cnt_reg, red_cnt_next;
    db_count_t          blue_cnt_reg, blue_cnt_next;
    logic               counting_reg, counting_next;
    logic               editing_reg, editing_next;
    logic               dashes_reg, dashes_next;
    logic [SEL_W-1:0]   sel_reg, sel_next;
    logic [TPS_W-1:0]   phase_reg, phase_next;
    digit_t             set_reg [DIGITS];
    digit_t             set_next [DIGITS];
    digit_t             elapsed_reg [DIGITS];
    digit_t             elapsed_next [DIGITS];
    seg_t               seg_next [DIGITS];

    db_result_t         red_db;
    db_result_t         blue_db;
    digit_t             sel_max;
    logic [DIG_W:0]     step_sum;
    logic               blank;
    logic [TPS_W-1:0]   phase_inc;
    logic               advance;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign out_valid       = out_valid_reg;
    assign digit0_segments = seg_reg[0];
    assign digit1_segments = seg_reg[1];
    assign digit2_segments = seg_reg[2];
    assign digit3_segments = seg_reg[3];
    assign counting_flag   = counting_flag_reg;
    assign set_mode_flag   = set_mode_flag_reg;

    always_comb
    begin
        red_db        = debounce(red_cnt_reg, debounce_ticks_reg, red_reg);
        blue_db       = debounce(blue_cnt_reg, debounce_ticks_reg, blue_reg);
        red_cnt_next  = red_db.count;
        blue_cnt_next = blue_db.count;
        counting_next = counting_reg;
        editing_next  = editing_reg;
        dashes_next   = dashes_reg;
        sel_next      = sel_reg;
        set_next      = set_reg;
        elapsed_next  = elapsed_reg;
        sel_max       = sel_reg[0] ? DIGIT_MAX_UNITS : DIGIT_MAX_TENS;
        step_sum      = {1'b0, set_reg[sel_reg]} + (DIG_W+1)'(1);

        // red: step digit, or stop, or start
        if (red_db.press) begin
            dashes_next = 1'b0;
            if (editing_reg) begin
                if (step_sum > {1'b0, sel_max}) begin
                    step_sum = step_sum - ({1'b0, sel_max} + (DIG_W+1)'(1));
                end
                set_next[sel_reg] = step_sum[DIG_W-1:0];
            end
            else if (counting_reg) begin
                counting_next = 1'b0;
                set_next      = elapsed_reg;
            end
            else begin
                counting_next = 1'b1;
                elapsed_next  = set_reg;
            end
        end

        // blue: enter set mode, advance digit, or leave set mode after the last digit
        if (blue_db.press) begin
            dashes_next = 1'b0;
            if (editing_next) begin
                if (sel_reg == SEL_W'(DIGITS - 1)) begin
                    editing_next = 1'b0;
                    sel_next     = '0;
                end
                else begin
                    sel_next = sel_reg + SEL_W'(1);
                end
            end
            else begin
                sel_next      = '0;
                editing_next  = 1'b1;
                counting_next = 1'b0;
                set_next      = elapsed_next;
            end
        end

        blank = phase_reg >= (tps_reg >> 1);
        for (int i = 0; i < DIGITS; i++) begin
            if (counting_next) begin
                seg_next[i] = seg_encode(elapsed_next[i]);
            end
            else if (editing_next && sel_next == SEL_W'(i) && blank) begin
                seg_next[i] = SEG_BLANK;
            end
            else if (!editing_next && dashes_next) begin
                seg_next[i] = SEG_DASH;
            end
            else begin
                seg_next[i] = seg_encode(set_next[i]);
            end
        end

        // end of second: BCD increment, 99:59 rolls to 00:00
        phase_inc  = phase_reg + TPS_W'(1);
        phase_next = phase_inc;
        if (phase_inc >= tps_reg) begin
            phase_next = '0;
            if (counting_next) begin
                if (elapsed_next[3] != DIGIT_MAX_UNITS) begin
                    elapsed_next[3] = elapsed_next[3] + digit_t'(1);
                end
                else begin
                    elapsed_next[3] = '0;
                    if (elapsed_next[2] != DIGIT_MAX_TENS) begin
                        elapsed_next[2] = elapsed_next[2] + digit_t'(1);
                    end
                    else begin
                        elapsed_next[2] = '0;
                        if (elapsed_next[1] != DIGIT_MAX_UNITS) begin
                            elapsed_next[1] = elapsed_next[1] + digit_t'(1);
                        end
                        else begin
                            elapsed_next[1] = '0;
                            if (elapsed_next[0] != DIGIT_MAX_UNITS) begin
                                elapsed_next[0] = elapsed_next[0] + digit_t'(1);
                            end
                            else begin
                                elapsed_next[0] = '0;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            debounce_ticks_reg <= DEBOUNCE_RESET;
            tps_reg            <= TPS_RESET;
            red_cnt_reg        <= '0;
            blue_cnt_reg       <= '0;
            counting_reg       <= 1'b0;
            editing_reg        <= 1'b0;
            dashes_reg         <= 1'b1;
            sel_reg            <= '0;
            phase_reg          <= '0;
            for (int i = 0; i < DIGITS; i++) begin
                set_reg[i]     <= '0;
                elapsed_reg[i] <= '0;
            end
        end
        else begin
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_DEBOUNCE_TICKS:   debounce_ticks_reg <= cfg_data[DB_W-1:0];
                    REG_TICKS_PER_SECOND: tps_reg            <= cfg_data[TPS_W-1:0];
                    default:              tps_reg            <= tps_reg;
                endcase
            end
            if (advance) begin
                red_cnt_reg  <= red_cnt_next;
                blue_cnt_reg <= blue_cnt_next;
                counting_reg <= counting_next;
                editing_reg  <= editing_next;
                dashes_reg   <= dashes_next;
                sel_reg      <= sel_next;
                phase_reg    <= phase_next;
                set_reg      <= set_next;
                elapsed_reg  <= elapsed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            red_reg  <= red_level;
            blue_reg <= blue_level;
        end
        if (advance) begin
            seg_reg           <= seg_next;
            counting_flag_reg <= counting_next;
            set_mode_flag_reg <= editing_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(counting_reg && editing_reg))
        else $error("counting and set mode both active");

    assert property (@(posedge clk) disable iff (!rst_n)
        !editing_reg |-> (sel_reg == '0))
        else $error("digit selected outside set mode");

    assert property (@(posedge clk) disable iff (!rst_n)
        (elapsed_reg[2] <= DIGIT_MAX_TENS) && (elapsed_reg[3] <= DIGIT_MAX_UNITS))
        else $error("seconds digits out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("held tick lost from input register");

endmodule
